// File: src/s2a_pkg.sv
// ----------------------------------------------------------------------------
// s2a_pkg
// Types and constants shared by the signed integer to decimal text blocks.
// ----------------------------------------------------------------------------
package s2a_pkg;

  localparam int VALUE_W           = 32;
  localparam int NUM_DIGITS        = 10;
  localparam int DIGIT_IDX_W       = 4;
  localparam int BITS_PER_STAGE    = 8;
  localparam int NUM_DABBLE_STAGES = VALUE_W / BITS_PER_STAGE;

  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;

  // Ten packed BCD digits, digit 0 is the least significant.
  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  // One number on its way through the conversion pipeline. The binary
  // magnitude is shifted out of its top bit into the BCD digits.
  typedef struct packed {
    logic                 neg;
    bcd_t                 bcd;
    logic [VALUE_W-1:0]   bin;
  } s2a_work_t;

endpackage

// File: src/s2a_dabble_stage.sv
// ----------------------------------------------------------------------------
// s2a_dabble_stage
// One registered pipeline stage of the binary to BCD conversion: eight
// shift-and-add-3 steps on the number held in the work word.
// ----------------------------------------------------------------------------
module s2a_dabble_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  s2a_pkg::s2a_work_t   work_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output s2a_pkg::s2a_work_t   work_o
);
  import s2a_pkg::*;

  logic      valid_q;
  s2a_work_t work_d;
  s2a_work_t work_q;

  always_comb begin
    work_d = work_i;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (work_d.bcd[d] >= 4'd5) begin
          work_d.bcd[d] = work_d.bcd[d] + 4'd3;
        end
      end
      {work_d.bcd, work_d.bin} = {work_d.bcd, work_d.bin} << 1;
    end
  end

  // The stage takes a new word when it is empty or its word leaves now.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// File: src/s2a_serializer.sv
// ----------------------------------------------------------------------------
// s2a_serializer
// Holds one converted number and sends its text one character per transfer:
// an optional minus sign, then the digits from the most significant nonzero
// digit down to digit zero.
// ----------------------------------------------------------------------------
module s2a_serializer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  s2a_pkg::s2a_work_t   work_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [7:0]           character_o,
  output logic                 last_o
);
  import s2a_pkg::*;

  logic                   busy_q;
  logic                   sign_q;
  logic [DIGIT_IDX_W-1:0] idx_q;
  bcd_t                   bcd_q;
  logic [DIGIT_IDX_W-1:0] top_idx;
  logic                   out_xfer;

  // Position of the highest nonzero digit; zero shows as the single digit 0.
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (work_i.bcd[d] != 4'd0) begin
        top_idx = DIGIT_IDX_W'(d);
      end
    end
  end

  assign valid_o  = busy_q;
  assign out_xfer = busy_q && ready_i;
  assign last_o   = !sign_q && (idx_q == '0);
  assign ready_o  = !busy_q || (out_xfer && last_o);

  assign character_o = sign_q ? ASCII_MINUS : (ASCII_ZERO | {4'b0000, bcd_q[idx_q]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      idx_q  <= '0;
    end else if (ready_o && valid_i) begin
      busy_q <= 1'b1;
      sign_q <= work_i.neg;
      idx_q  <= top_idx;
    end else if (out_xfer) begin
      if (sign_q) begin
        sign_q <= 1'b0;
      end else if (idx_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q - DIGIT_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      bcd_q <= work_i.bcd;
    end
  end

endmodule

// File: src/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i, in_ready_o, value_i) takes one two's
//   complement number per transfer. The output channel (out_valid_o,
//   out_ready_i, character_o, last_o) sends its text one character per
//   transfer, most significant digit first, with a leading '-' for negative
//   numbers; last_o marks the final character. Zero gives "0", and the most
//   negative value gives "-2147483648".
//   The input transfer loads the magnitude stage; four BCD stages of eight
//   bits each and the character sender follow. Up to five further numbers
//   are held in the pipeline.
//   A number's text has 1 to 11 characters, sent one per output transfer;
//   the next number's text follows its predecessor's last character without
//   a gap when that next number already waits in the last BCD stage.
//   A stalled receiver holds the current character; the pipeline stages fill
//   behind it and in_ready_o drops once they are all full.
//   Reset empties every stage; no character is pending after it.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  character_o,
  output logic        last_o
);
  import s2a_pkg::*;

  logic               s0_valid_q;
  logic               s0_neg_q;
  logic [VALUE_W-1:0] s0_mag_q;

  s2a_work_t work   [NUM_DABBLE_STAGES+1];
  logic      valid  [NUM_DABBLE_STAGES+1];
  logic      ready  [NUM_DABBLE_STAGES+1];

  // Magnitude stage: the most negative value negates to itself, which is its
  // correct unsigned magnitude.
  assign in_ready_o = !s0_valid_q || ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s0_neg_q <= value_i[VALUE_W-1];
      s0_mag_q <= value_i[VALUE_W-1] ? (~value_i + VALUE_W'(1)) : value_i;
    end
  end

  assign valid[0] = s0_valid_q;
  assign work[0]  = '{neg: s0_neg_q, bcd: '0, bin: s0_mag_q};

  for (genvar g = 0; g < NUM_DABBLE_STAGES; g++) begin : g_dabble
    s2a_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[g]),
      .ready_o (ready[g]),
      .work_i  (work[g]),
      .valid_o (valid[g+1]),
      .ready_i (ready[g+1]),
      .work_o  (work[g+1])
    );
  end

  s2a_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid[NUM_DABBLE_STAGES]),
    .ready_o     (ready[NUM_DABBLE_STAGES]),
    .work_i      (work[NUM_DABBLE_STAGES]),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // A minus sign is always followed by at least one digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (character_o == ASCII_MINUS) |-> !last_o)
    else $error("minus sign marked as last character");

  // Every character other than the sign is a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (character_o != ASCII_MINUS)
      |-> (character_o >= ASCII_ZERO) && (character_o <= ASCII_NINE))
    else $error("character is not a decimal digit");

  // The input is only held off while the magnitude stage is full and stuck.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s0_valid_q && !ready[0])
    else $error("input held off with room in the pipeline");

  // A stalled output keeps its character until the transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(character_o) && $stable(last_o))
    else $error("pending character changed before its transfer");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the signed integer to decimal ASCII converter against its own
// predictor. Each accepted number queues its expected characters, and every
// character transfer is compared with the oldest one in order, with random
// idling on both channels followed by a stretch at full rate.
// ----------------------------------------------------------------------------
module tb;

  import s2a_pkg::*;

  typedef struct packed {
    logic [7:0] char;
    logic       last;
  } text_char_t;

  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_CYCLES  = 16;
  localparam int RANDOM_ITEMS  = 140;
  localparam int FULL_RATE_ITEMS = 70;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  character;
  logic        last;

  // Set for the final stretch, where neither side idles.
  logic        calm;

  text_char_t  expected_text[$];
  int          text_errors;

  signed_int_to_decimal_ascii i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .character_o (character),
    .last_o      (last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Queues the decimal text of one number, sign first, then digits from the
  // most significant one down.
  function automatic void predict_text(input logic [31:0] bits);
    logic       negative;
    logic [31:0] mag;
    logic [3:0] digits[NUM_DIGITS];
    int         count;
    text_char_t c;
    negative = bits[31];
    // Unsigned negation keeps the most negative value's magnitude intact.
    mag = negative ? 32'(32'd0 - bits) : bits;
    count = 0;
    do begin
      digits[count] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      count++;
    end while (mag != 32'd0 && count < NUM_DIGITS);
    if (negative) begin
      c.char = ASCII_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = count - 1; i >= 0; i--) begin
      c.char = ASCII_ZERO + 8'(digits[i]);
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    if (text_errors < MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
    text_errors++;
  endfunction

  // Called at a rising edge. Valid stays high after the transfer so that a
  // following call can keep it up without a gap.
  task automatic send_number(input logic [31:0] number);
    logic taken;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= number;
    do begin
      @(negedge clk);
      taken = in_ready;
      if (taken) predict_text(number);
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic finish_burst();
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  // Random magnitude with a random number of digits, so short and long texts
  // are about equally common.
  function automatic logic [31:0] random_number();
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    int          width;
    logic        negative;
    width = $urandom_range(1, NUM_DIGITS);
    negative = 1'($urandom_range(0, 1));
    lo = (width == 1) ? 0 : 1;
    for (int i = 1; i < width; i++) lo = lo * 10;
    if (width == NUM_DIGITS) hi = negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else hi = lo * 10 - 1 + ((width == 1) ? 10 : 0);
    if (width == 1) hi = 9;
    mag = $urandom_range(lo, hi);
    return negative ? 32'(32'd0 - mag) : mag;
  endfunction

  task automatic test_extremes();
    logic [31:0] corners[$];
    corners = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
                32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                32'd1000000000, 32'd999999999, -32'sd999999999,
                32'd1234567890, -32'sd1234567890, 32'h5555_5555,
                32'hAAAA_AAAA, 32'd0, -32'sd1000000000};
    foreach (corners[i]) send_number(corners[i]);
    finish_burst();
  endtask

  task automatic test_random_numbers();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Mix in raw 32-bit patterns so every bit of the field toggles.
      if ($urandom_range(0, 2) == 0) send_number($urandom());
      else send_number(random_number());
      if (i != RANDOM_ITEMS - 1 && $urandom_range(0, 40) == 0) finish_burst();
    end
    finish_burst();
  endtask

  task automatic test_full_rate();
    calm = 1'b1;
    for (int i = 0; i < FULL_RATE_ITEMS; i++) begin
      if (i % 2 == 0) send_number($urandom());
      else send_number(random_number());
    end
    finish_burst();
  endtask

  // Receiver pacing: random stall bursts until the final stretch.
  initial begin : sink_pacer
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Sampled at the falling edge, where every signal already holds the value
  // that the next rising edge will see.
  always @(negedge clk) begin : text_checker
    text_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_text.size() == 0) begin
        note_mismatch($sformatf("unexpected transfer char=%h last=%b", character, last));
      end else begin
        want = expected_text.pop_front();
        if (character !== want.char)
          note_mismatch($sformatf("char expected %h actual %h", want.char, character));
        if (last !== want.last)
          note_mismatch($sformatf("last expected %b actual %b", want.last, last));
      end
    end
  end

  initial begin : run
    calm        = 1'b0;
    text_errors = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    value    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random_numbers();
    test_full_rate();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (text_errors == 0 && expected_text.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #400_000;
    $display("FAILURE");
    $finish;
  end

endmodule
